// ===== hdl/gisa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// GPIO interrupt slot allocator package
// Shared widths, codes and the structs passed between the sequencer and the
// slot table.
// ---------------------------------------------------------------------------
package gisa_pkg;

  localparam int SLOT_W    = 3;
  localparam int PIN_W     = 9;
  localparam int LINE_W    = 8;
  localparam int CNT_CFG_W = 4;
  localparam int POL_SHIFT = 16;
  localparam logic [31:0] FILT_VAL  = 32'h7;
  localparam logic [63:0] LINE_MASK = 64'hFF;

  typedef enum logic [1:0] {
    MODE_REQUEST  = 2'd0,
    MODE_RELEASE  = 2'd1,
    MODE_POLARITY = 2'd2,
    MODE_GRANT    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_INVALID_ARGS = 3'd1,
    ST_NO_RESOURCES = 3'd2,
    ST_EXISTS       = 3'd3,
    ST_NOT_FOUND    = 3'd4,
    ST_CANCELED     = 3'd5,
    ST_GRANT_FAILED = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  typedef struct packed {
    logic              free_found;
    logic [SLOT_W-1:0] free_slot;
    logic              pin_found;
    logic [SLOT_W-1:0] pin_slot;
    logic              grant_match;
  } scan_result_t;

  typedef struct packed {
    logic              set;
    logic              clear;
    logic [SLOT_W-1:0] slot;
    logic [PIN_W-1:0]  pin;
  } table_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/gisa_slot_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Slot table and scanner
// Holds the busy flag and pin of every slot and walks the slots one per
// cycle through a single pin comparator to find the lowest free slot, the
// slot holding a pin and whether the granted slot still holds that pin.
// ---------------------------------------------------------------------------
module gisa_slot_table #(
  parameter int MAX_SLOTS = 8
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          scan_start,
  input  wire [gisa_pkg::PIN_W-1:0]    pin,
  input  wire [gisa_pkg::SLOT_W-1:0]   grant_slot,
  input  wire [gisa_pkg::CNT_CFG_W-1:0] usable,
  input  gisa_pkg::table_cmd_t         cmd,
  output logic                         scan_done,
  output gisa_pkg::scan_result_t       result
);

  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  logic [MAX_SLOTS-1:0]       slot_busy;
  logic [gisa_pkg::PIN_W-1:0] slot_pin [MAX_SLOTS];
  logic [CNT_W-1:0]           idx;
  logic                       scanning;

  logic [IDX_W-1:0]              cur;
  logic                          in_range;
  logic                          pin_eq;
  logic [gisa_pkg::SLOT_W-1:0]   cur_slot;

  assign cur      = idx[IDX_W-1:0];
  assign cur_slot = gisa_pkg::SLOT_W'(cur);
  assign in_range = gisa_pkg::CNT_CFG_W'(idx) < usable;
  assign pin_eq   = slot_busy[cur] && (slot_pin[cur] == pin);

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning  <= 1'b0;
      scan_done <= 1'b0;
      idx       <= '0;
      result    <= '0;
    end else begin
      scan_done <= 1'b0;
      if (scan_start) begin
        scanning <= 1'b1;
        idx      <= '0;
        result   <= '0;
      end else if (scanning) begin
        if (in_range && !slot_busy[cur] && !result.free_found) begin
          result.free_found <= 1'b1;
          result.free_slot  <= cur_slot;
        end
        if (in_range && pin_eq && !result.pin_found) begin
          result.pin_found <= 1'b1;
          result.pin_slot  <= cur_slot;
        end
        if ((cur_slot == grant_slot) && pin_eq) begin
          result.grant_match <= 1'b1;
        end
        if (idx == CNT_W'(MAX_SLOTS - 1)) begin
          scanning  <= 1'b0;
          scan_done <= 1'b1;
        end else begin
          idx <= idx + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_busy <= '0;
    end else if (cmd.set) begin
      slot_busy[cmd.slot[IDX_W-1:0]] <= 1'b1;
    end else if (cmd.clear) begin
      slot_busy[cmd.slot[IDX_W-1:0]] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set) begin
      slot_pin[cmd.slot[IDX_W-1:0]] <= cmd.pin;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/gpio_irq_slot_allocator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// GPIO interrupt slot allocator
// Takes request, release, polarity and grant outcome words and keeps the
// slot table and the edge/polarity, filter select and pin select images.
// ---------------------------------------------------------------------------
// A word is accepted at a rising edge where start is high and busy is low.
// The block then walks its MAX_SLOTS slots, one per cycle, through a single
// pin comparator, and then decides and updates. done is high
// for exactly one cycle with the result; the receiver cannot stall, and the
// result ports hold their value until the next result.
// busy is high from the accept edge until done is shown, so a new word can
// be accepted in the cycle that done is shown, but not before the block is
// through with the last word.
// The slot count register is written through cfg_write and cfg_data; the user
// must write it only while the block is idle, which the block does not enforce.
// Reset clears all slots and register images and sets the slot count to eight.
// ---------------------------------------------------------------------------
module gpio_irq_slot_allocator_top #(
  parameter int MAX_SLOTS = 8,
  parameter int MAX_PIN   = 255
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_write,
  input  wire  [3:0]  cfg_data,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  mode,
  input  wire  [8:0]  pin,
  input  wire  [2:0]  irq_mode,
  input  wire         polarity_high,
  input  wire         pin_known,
  input  wire  [7:0]  hw_line,
  input  wire  [2:0]  grant_slot,
  input  wire         grant_ok,
  output logic        done,
  output logic [2:0]  status,
  output logic [2:0]  slot,
  output logic [31:0] edge_polarity_word,
  output logic [31:0] filter_select_word,
  output logic [63:0] pin_select_word,
  output logic [1:0]  forwarded_mode
);

  gisa_pkg::state_t  state;
  gisa_pkg::state_t  state_next;
  logic [3:0]        slots_in_use;
  logic [3:0]        usable;

  gisa_pkg::mode_t   mode_r;
  logic [8:0]        pin_r;
  logic [2:0]        irq_mode_r;
  logic              polarity_high_r;
  logic              pin_known_r;
  logic [7:0]        hw_line_r;
  logic [2:0]        grant_slot_r;
  logic              grant_ok_r;

  logic [31:0]       edge_polarity_reg;
  logic [31:0]       filter_select_reg;
  logic [63:0]       pin_select_reg;
  logic [31:0]       edge_polarity_next;
  logic [31:0]       filter_select_next;
  logic [63:0]       pin_select_next;

  gisa_pkg::status_t result_status;
  gisa_pkg::status_t result_status_next;
  logic [2:0]        result_slot;
  logic [2:0]        result_slot_next;
  logic [1:0]        result_fwd;
  logic [1:0]        result_fwd_next;

  logic                   accept;
  logic                   finish;
  logic                   scan_done;
  gisa_pkg::scan_result_t scan;
  gisa_pkg::table_cmd_t   cmd;

  logic [2:0]  sel;
  logic [31:0] ebit;
  logic [31:0] pbit;
  logic        pin_bad;

  assign busy   = (state != gisa_pkg::S_IDLE);
  assign accept = start && !busy;
  assign finish = (state == gisa_pkg::S_SCAN) && scan_done;
  assign usable = (slots_in_use > 4'(MAX_SLOTS)) ? 4'(MAX_SLOTS) : slots_in_use;

  gisa_slot_table #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .scan_start (accept),
    .pin        (pin_r),
    .grant_slot (grant_slot_r),
    .usable     (usable),
    .cmd        (cmd),
    .scan_done  (scan_done),
    .result     (scan)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      gisa_pkg::S_IDLE: begin
        if (start) state_next = gisa_pkg::S_SCAN;
      end
      gisa_pkg::S_SCAN: begin
        if (scan_done) state_next = gisa_pkg::S_IDLE;
      end
      default: state_next = gisa_pkg::S_IDLE;
    endcase
  end

  assign pin_bad = pin_r > 9'(MAX_PIN);
  assign sel = (mode_r == gisa_pkg::MODE_REQUEST) ? scan.free_slot : scan.pin_slot;
  assign ebit = 32'd1 << sel;
  assign pbit = ebit << gisa_pkg::POL_SHIFT;

  always_comb begin
    edge_polarity_next = edge_polarity_reg;
    filter_select_next = filter_select_reg;
    pin_select_next    = pin_select_reg;
    result_status_next = gisa_pkg::ST_OK;
    result_slot_next   = 3'd0;
    result_fwd_next    = 2'd0;
    cmd                = '0;
    cmd.pin            = pin_r;
    unique case (mode_r)
      gisa_pkg::MODE_REQUEST: begin
        if (pin_bad) begin
          result_status_next = gisa_pkg::ST_INVALID_ARGS;
        end else if (!scan.free_found) begin
          result_status_next = gisa_pkg::ST_NO_RESOURCES;
        end else if (scan.pin_found) begin
          result_status_next = gisa_pkg::ST_EXISTS;
        end else if (!pin_known_r) begin
          result_status_next = gisa_pkg::ST_NOT_FOUND;
        end else if (irq_mode_r[2]) begin
          result_status_next = gisa_pkg::ST_INVALID_ARGS;
        end else begin
          edge_polarity_next = irq_mode_r[1] ? (edge_polarity_reg & ~ebit)
                                             : (edge_polarity_reg | ebit);
          edge_polarity_next = irq_mode_r[0] ? (edge_polarity_next | pbit)
                                             : (edge_polarity_next & ~pbit);
          filter_select_next = filter_select_reg | (gisa_pkg::FILT_VAL << {sel, 2'b00});
          pin_select_next    = (pin_select_reg & ~(gisa_pkg::LINE_MASK << {sel, 3'b000}))
                             | (64'(hw_line_r) << {sel, 3'b000});
          cmd.set            = finish;
          cmd.slot           = sel;
          result_slot_next   = sel;
          result_fwd_next    = {irq_mode_r[1], 1'b0};
        end
      end
      gisa_pkg::MODE_RELEASE: begin
        if (!scan.pin_found) begin
          result_status_next = gisa_pkg::ST_NOT_FOUND;
        end else begin
          cmd.clear        = finish;
          cmd.slot         = sel;
          result_slot_next = sel;
        end
      end
      gisa_pkg::MODE_POLARITY: begin
        if (pin_bad) begin
          result_status_next = gisa_pkg::ST_INVALID_ARGS;
        end else if (!scan.pin_found) begin
          result_status_next = gisa_pkg::ST_NOT_FOUND;
        end else begin
          edge_polarity_next = polarity_high_r ? (edge_polarity_reg & ~pbit)
                                               : (edge_polarity_reg | pbit);
          result_slot_next   = sel;
        end
      end
      gisa_pkg::MODE_GRANT: begin
        result_slot_next = grant_slot_r;
        if (!scan.grant_match) begin
          result_status_next = gisa_pkg::ST_CANCELED;
        end else if (!grant_ok_r) begin
          result_status_next = gisa_pkg::ST_GRANT_FAILED;
          cmd.clear          = finish;
          cmd.slot           = grant_slot_r;
        end
      end
      default: begin
        result_status_next = gisa_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= gisa_pkg::S_IDLE;
      slots_in_use      <= 4'd8;
      done              <= 1'b0;
      edge_polarity_reg <= '0;
      filter_select_reg <= '0;
      pin_select_reg    <= '0;
    end else begin
      state <= state_next;
      done  <= finish;
      if (cfg_write) begin
        slots_in_use <= cfg_data;
      end
      if (finish) begin
        edge_polarity_reg <= edge_polarity_next;
        filter_select_reg <= filter_select_next;
        pin_select_reg    <= pin_select_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r          <= gisa_pkg::mode_t'(mode);
      pin_r           <= pin;
      irq_mode_r      <= irq_mode;
      polarity_high_r <= polarity_high;
      pin_known_r     <= pin_known;
      hw_line_r       <= hw_line;
      grant_slot_r    <= grant_slot;
      grant_ok_r      <= grant_ok;
    end
    if (finish) begin
      result_status <= result_status_next;
      result_slot   <= result_slot_next;
      result_fwd    <= result_fwd_next;
    end
  end

  assign status             = result_status;
  assign slot               = result_slot;
  assign forwarded_mode     = result_fwd;
  assign edge_polarity_word = edge_polarity_reg;
  assign filter_select_word = filter_select_reg;
  assign pin_select_word    = pin_select_reg;

endmodule
`default_nettype wire

// ===== test/tb_gpio_irq_slot_allocator_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// GPIO interrupt slot allocator testbench
// Drives request, release, polarity and grant outcome words through the
// start/busy handshake and checks every done result against a predicted
// slot table and register images. The run covers a directed opening and
// then random phases at different slot counts and sender idle rates.
// ---------------------------------------------------------------------------
module tb_gpio_irq_slot_allocator_top;

  localparam int NUM_SLOTS = 8;
  localparam int PIN_LIMIT = 255;
  localparam int LATENCY   = NUM_SLOTS + 2;

  typedef struct {
    gisa_pkg::mode_t mode;
    logic [8:0]  pin;
    logic [2:0]  irq_mode;
    logic        polarity_high;
    logic        pin_known;
    logic [7:0]  hw_line;
    logic [2:0]  grant_slot;
    logic        grant_ok;
  } word_t;

  typedef struct {
    gisa_pkg::status_t status;
    logic [2:0]  slot;
    logic [31:0] edge_polarity_word;
    logic [31:0] filter_select_word;
    logic [63:0] pin_select_word;
    logic [1:0]  forwarded_mode;
  } result_t;

  class slot_scoreboard;
    logic [3:0]  slot_count;
    logic [7:0]  busy_mask;
    logic [8:0]  held_pin [NUM_SLOTS];
    logic [31:0] edge_pol_img;
    logic [31:0] filter_img;
    logic [63:0] pin_sel_img;
    result_t     expected_q [$];
    int          errors;
    int          words;
    int          results;
    int          status_seen [8];

    function new();
      slot_count   = 4'd8;
      busy_mask    = '0;
      edge_pol_img = '0;
      filter_img   = '0;
      pin_sel_img  = '0;
      errors       = 0;
      words        = 0;
      results      = 0;
      foreach (held_pin[i]) held_pin[i] = 9'd256;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int usable();
      return (slot_count > NUM_SLOTS) ? NUM_SLOTS : int'(slot_count);
    endfunction

    function int lookup_pin(logic [8:0] p);
      for (int i = 0; i < usable(); i++)
        if (busy_mask[i] && held_pin[i] == p) return i;
      return -1;
    endfunction

    function void release_slot(int s);
      busy_mask[s] = 1'b0;
      held_pin[s]  = 9'd256;
    endfunction

    function void note_word(word_t w);
      result_t r;
      int n;
      int s;
      r.status = gisa_pkg::ST_OK;
      r.slot = '0;
      r.forwarded_mode = '0;
      case (w.mode)
        gisa_pkg::MODE_REQUEST: begin
          n = usable();
          s = n;
          for (int i = 0; i < n; i++)
            if (!busy_mask[i]) begin
              s = i;
              break;
            end
          if (w.pin > PIN_LIMIT) r.status = gisa_pkg::ST_INVALID_ARGS;
          else if (s >= n) r.status = gisa_pkg::ST_NO_RESOURCES;
          else if (lookup_pin(w.pin) >= 0) r.status = gisa_pkg::ST_EXISTS;
          else if (!w.pin_known) r.status = gisa_pkg::ST_NOT_FOUND;
          else if (w.irq_mode > 3) r.status = gisa_pkg::ST_INVALID_ARGS;
          else begin
            edge_pol_img[s] = (w.irq_mode < 2);
            edge_pol_img[s + gisa_pkg::POL_SHIFT] = w.irq_mode[0];
            filter_img = filter_img | (gisa_pkg::FILT_VAL << (4 * s));
            pin_sel_img[gisa_pkg::LINE_W * s +: gisa_pkg::LINE_W] = w.hw_line;
            busy_mask[s] = 1'b1;
            held_pin[s] = w.pin;
            r.slot = s[2:0];
            r.forwarded_mode = {w.irq_mode[1], 1'b0};
          end
        end
        gisa_pkg::MODE_RELEASE: begin
          s = lookup_pin(w.pin);
          if (s < 0) r.status = gisa_pkg::ST_NOT_FOUND;
          else begin
            release_slot(s);
            r.slot = s[2:0];
          end
        end
        gisa_pkg::MODE_POLARITY: begin
          s = lookup_pin(w.pin);
          if (w.pin > PIN_LIMIT) r.status = gisa_pkg::ST_INVALID_ARGS;
          else if (s < 0) r.status = gisa_pkg::ST_NOT_FOUND;
          else begin
            edge_pol_img[s + gisa_pkg::POL_SHIFT] = !w.polarity_high;
            r.slot = s[2:0];
          end
        end
        default: begin
          r.slot = w.grant_slot;
          if (!busy_mask[w.grant_slot] || held_pin[w.grant_slot] != w.pin)
            r.status = gisa_pkg::ST_CANCELED;
          else if (!w.grant_ok) begin
            release_slot(int'(w.grant_slot));
            r.status = gisa_pkg::ST_GRANT_FAILED;
          end
        end
      endcase
      r.edge_polarity_word = edge_pol_img;
      r.filter_select_word = filter_img;
      r.pin_select_word = pin_sel_img;
      expected_q.insert(expected_q.size(), r);
      words++;
    endfunction

    function void compare_field(string field, logic [63:0] exp, logic [63:0] act);
      if (exp !== act) begin
        $error("%s mismatch: expected %0h, actual %0h", field, exp, act);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_q.size() == 0) begin
        $error("result with no word pending: status %0d slot %0d", got.status, got.slot);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      results++;
      status_seen[exp.status]++;
      compare_field("status", 64'(exp.status), 64'(got.status));
      compare_field("slot", 64'(exp.slot), 64'(got.slot));
      compare_field("edge_polarity_word", 64'(exp.edge_polarity_word),
                    64'(got.edge_polarity_word));
      compare_field("filter_select_word", 64'(exp.filter_select_word),
                    64'(got.filter_select_word));
      compare_field("pin_select_word", exp.pin_select_word, got.pin_select_word);
      compare_field("forwarded_mode", 64'(exp.forwarded_mode), 64'(got.forwarded_mode));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [3:0]  cfg_data = '0;
  logic        start = 1'b0;
  logic [1:0]  mode = '0;
  logic [8:0]  pin = '0;
  logic [2:0]  irq_mode = '0;
  logic        polarity_high = 1'b0;
  logic        pin_known = 1'b0;
  logic [7:0]  hw_line = '0;
  logic [2:0]  grant_slot = '0;
  logic        grant_ok = 1'b0;
  logic        busy;
  logic        done;
  logic [2:0]  status;
  logic [2:0]  slot;
  logic [31:0] edge_polarity_word;
  logic [31:0] filter_select_word;
  logic [63:0] pin_select_word;
  logic [1:0]  forwarded_mode;

  slot_scoreboard sb = new();
  int idle_pct = 0;
  int settings_done = 0;
  logic [8:0] pin_pool [8];

  gpio_irq_slot_allocator_top #(
    .MAX_SLOTS(NUM_SLOTS),
    .MAX_PIN(PIN_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .start(start),
    .busy(busy),
    .mode(mode),
    .pin(pin),
    .irq_mode(irq_mode),
    .polarity_high(polarity_high),
    .pin_known(pin_known),
    .hw_line(hw_line),
    .grant_slot(grant_slot),
    .grant_ok(grant_ok),
    .done(done),
    .status(status),
    .slot(slot),
    .edge_polarity_word(edge_polarity_word),
    .filter_select_word(filter_select_word),
    .pin_select_word(pin_select_word),
    .forwarded_mode(forwarded_mode)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_t got;
    if (!rst && done) begin
      got.status = gisa_pkg::status_t'(status);
      got.slot = slot;
      got.edge_polarity_word = edge_polarity_word;
      got.filter_select_word = filter_select_word;
      got.pin_select_word = pin_select_word;
      got.forwarded_mode = forwarded_mode;
      sb.check_result(got);
    end
  end

  function automatic word_t make_word(gisa_pkg::mode_t m, int p, int irq, bit pol,
                                      bit known, int line, int gs, bit gok);
    word_t w;
    w.mode = m;
    w.pin = p[8:0];
    w.irq_mode = irq[2:0];
    w.polarity_high = pol;
    w.pin_known = known;
    w.hw_line = line[7:0];
    w.grant_slot = gs[2:0];
    w.grant_ok = gok;
    return w;
  endfunction

  function automatic logic [8:0] pick_pin(int held_pct);
    int held [$];
    int k;
    for (int i = 0; i < NUM_SLOTS; i++)
      if (sb.busy_mask[i]) held.insert(held.size(), i);
    k = $urandom_range(0, 99);
    if (held.size() > 0 && k < held_pct)
      return sb.held_pin[held[$urandom_range(0, held.size() - 1)]];
    if (k < 90) return pin_pool[$urandom_range(0, 7)];
    return 9'($urandom_range(0, 511));
  endfunction

  function automatic word_t random_word();
    word_t w;
    int r;
    int held [$];
    for (int i = 0; i < NUM_SLOTS; i++)
      if (sb.busy_mask[i]) held.insert(held.size(), i);
    w.irq_mode = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 3))
                                               : 3'($urandom_range(4, 7));
    w.polarity_high = 1'($urandom_range(0, 1));
    w.pin_known = ($urandom_range(0, 99) < 90);
    w.hw_line = 8'($urandom_range(0, 255));
    w.grant_slot = 3'($urandom_range(0, 7));
    w.grant_ok = ($urandom_range(0, 99) < 70);
    r = $urandom_range(0, 99);
    if (r < 35) begin
      w.mode = gisa_pkg::MODE_REQUEST;
      w.pin = pick_pin(20);
    end else if (r < 60) begin
      w.mode = gisa_pkg::MODE_RELEASE;
      w.pin = pick_pin(70);
    end else if (r < 75) begin
      w.mode = gisa_pkg::MODE_POLARITY;
      w.pin = pick_pin(70);
    end else begin
      w.mode = gisa_pkg::MODE_GRANT;
      if (held.size() > 0 && $urandom_range(0, 99) < 75) begin
        w.grant_slot = 3'(held[$urandom_range(0, held.size() - 1)]);
        w.pin = sb.held_pin[w.grant_slot];
      end else begin
        w.pin = pick_pin(50);
      end
    end
    return w;
  endfunction

  task automatic send_word(word_t w);
    start <= 1'b1;
    mode <= w.mode;
    pin <= w.pin;
    irq_mode <= w.irq_mode;
    polarity_high <= w.polarity_high;
    pin_known <= w.pin_known;
    hw_line <= w.hw_line;
    grant_slot <= w.grant_slot;
    grant_ok <= w.grant_ok;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(w);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_slot_count(logic [3:0] value);
    drain();
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    sb.slot_count = value;
    settings_done++;
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [3:0] counts [10];
    int pcts [4];
    counts = '{4'd1, 4'd3, 4'd8, 4'd0, 4'd15, 4'd5, 4'd2, 4'd9, 4'd4, 4'd8};
    pcts = '{0, 47, 0, 24};
    pin_pool = '{9'd0, 9'd1, 9'd255, 9'd128, 9'd0, 9'd0, 9'd0, 9'd0};
    for (int i = 4; i < 8; i++) pin_pool[i] = 9'($urandom_range(0, 255));
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_slot_count(4'd8);

    send_word(make_word(gisa_pkg::MODE_REQUEST, 0, 0, 0, 1, 8'h00, 0, 0));
    send_word(make_word(gisa_pkg::MODE_REQUEST, 255, 3, 1, 1, 8'hFF, 7, 1));
    send_word(make_word(gisa_pkg::MODE_REQUEST, 511, 0, 0, 1, 8'h11, 0, 0));
    send_word(make_word(gisa_pkg::MODE_REQUEST, 256, 0, 0, 1, 8'h22, 0, 0));
    send_word(make_word(gisa_pkg::MODE_REQUEST, 0, 1, 0, 1, 8'h33, 0, 0));
    send_word(make_word(gisa_pkg::MODE_REQUEST, 10, 0, 0, 0, 8'h44, 0, 0));
    send_word(make_word(gisa_pkg::MODE_REQUEST, 11, 4, 0, 1, 8'h55, 0, 0));
    send_word(make_word(gisa_pkg::MODE_REQUEST, 12, 7, 0, 1, 8'h66, 0, 0));
    send_word(make_word(gisa_pkg::MODE_REQUEST, 20, 1, 0, 1, 8'hA5, 0, 0));
    send_word(make_word(gisa_pkg::MODE_REQUEST, 21, 2, 0, 1, 8'h5A, 0, 0));
    send_word(make_word(gisa_pkg::MODE_POLARITY, 300, 0, 1, 1, 0, 0, 0));
    send_word(make_word(gisa_pkg::MODE_POLARITY, 255, 0, 1, 1, 0, 0, 0));
    send_word(make_word(gisa_pkg::MODE_POLARITY, 20, 0, 0, 1, 0, 0, 0));
    send_word(make_word(gisa_pkg::MODE_POLARITY, 99, 0, 0, 1, 0, 0, 0));
    send_word(make_word(gisa_pkg::MODE_RELEASE, 99, 0, 0, 1, 0, 0, 0));
    send_word(make_word(gisa_pkg::MODE_GRANT, 0, 0, 0, 1, 0, 6, 1));
    send_word(make_word(gisa_pkg::MODE_GRANT, 255, 0, 0, 1, 0, 0, 1));
    send_word(make_word(gisa_pkg::MODE_GRANT, 0, 0, 0, 1, 0, 0, 1));
    send_word(make_word(gisa_pkg::MODE_GRANT, 255, 0, 0, 1, 0, 1, 0));
    send_word(make_word(gisa_pkg::MODE_RELEASE, 0, 0, 0, 1, 0, 0, 0));
    for (int i = 0; i < 7; i++)
      send_word(make_word(gisa_pkg::MODE_REQUEST, 30 + i, $urandom_range(0, 3), 0, 1,
                          $urandom_range(0, 255), 0, 0));

    for (int ph = 0; ph < 10; ph++) begin
      write_slot_count(counts[ph]);
      idle_pct = pcts[ph % 4];
      for (int n = 0; n < 125; n++) send_word(random_word());
    end
    drain();

    $display("Ran %0d words through %0d slot count settings; %0d results checked.",
             sb.words, settings_done, sb.results);
    $display("Statuses seen: ok %0d, invalid %0d, no slot %0d, exists %0d, %s %0d, %s %0d, %s %0d",
             sb.status_seen[gisa_pkg::ST_OK], sb.status_seen[gisa_pkg::ST_INVALID_ARGS],
             sb.status_seen[gisa_pkg::ST_NO_RESOURCES], sb.status_seen[gisa_pkg::ST_EXISTS],
             "not found", sb.status_seen[gisa_pkg::ST_NOT_FOUND],
             "canceled", sb.status_seen[gisa_pkg::ST_CANCELED],
             "grant failed", sb.status_seen[gisa_pkg::ST_GRANT_FAILED]);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
